>>> hdl/plc_pkg.sv
// Shared types, constants and codes for the positional list engine.
`default_nettype none
package plc_pkg;

  // List capacity and field widths.
  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int POS_W = 7;
  localparam int VAL_W = 16;
  localparam int ACT_W = 3;
  localparam int ST_W  = 2;

  // Action codes of an input transfer.
  localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_POS  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_HEAD = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REM_TAIL = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REM_POS  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_DUMP     = 3'd6;

  // Status codes of a result transfer.
  localparam logic [ST_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [ST_W-1:0] STAT_DUMP  = 2'd3;

  // Cell operations broadcast along the chain.
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] at;
    logic [CNT_W-1:0] last_idx;
    logic [VAL_W-1:0] din;
    logic [VAL_W-1:0] head;
  } plc_ctl_t;

endpackage
`default_nettype wire

>>> hdl/plc_cell.sv
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
`default_nettype none
module plc_cell
  import plc_pkg::*;
(
  input  wire logic             clk,
  input  wire plc_ctl_t         ctl,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic [VAL_W-1:0] right_val,
  output logic      [VAL_W-1:0] data_o
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic [CNT_W-1:0] my_idx;

  assign my_idx = CNT_W'(idx);

  // Select the next entry from the broadcast operation and this cell's place.
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (my_idx > ctl.at) begin
          data_nxt = left_val;
        end else if (my_idx == ctl.at) begin
          data_nxt = ctl.din;
        end
      end
      OP_REM: begin
        if (my_idx >= ctl.at) begin
          data_nxt = right_val;
        end
      end
      OP_ROT: begin
        if (my_idx == ctl.last_idx) begin
          data_nxt = ctl.head;
        end else begin
          data_nxt = right_val;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Entry storage; contents are meaningless until written.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
`default_nettype wire

>>> hdl/positional_list_engine.sv
// Top level of the positional list engine: sequencer, result register and cell chain.
//
// Usage: an input transfer (in_valid/in_ready) carries an action, a position and a
// handle. Each action gives its results on the out_ channel (out_valid/out_ready);
// last_of_run marks the final result of one input transfer. Action code 7 is taken
// and gives no result.
// Insert and remove shift all cells from the target place onward at once, so the
// result of such an action appears in the output register the cycle after the
// transfer; the engine can take a new action every cycle while the receiver keeps up.
// A dump of N entries rotates the chain once per emitted entry: the dump state puts
// the entries into the output register one per cycle while the receiver keeps up,
// and the input stays not ready until the last entry is registered. After the last
// rotation the list is back in its original order.
// When the receiver stalls, the output register holds its result and the input and
// any running dump wait until that result is transferred.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// no clearing pass is needed.
`default_nettype none
module positional_list_engine
  import plc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ACT_W-1:0] in_action,
  input  wire logic [POS_W-1:0] in_position,
  input  wire logic [VAL_W-1:0] in_entry_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [ST_W-1:0]  out_status,
  output logic      [VAL_W-1:0] out_result_value,
  output logic                  out_last_of_run
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic             state_r,    state_nxt;
  logic [CNT_W-1:0] occ_r,      occ_nxt;
  logic [IDX_W-1:0] dcnt_r,     dcnt_nxt;
  logic             ovalid_r,   ovalid_nxt;
  logic [ST_W-1:0]  ostat_r,    ostat_nxt;
  logic [VAL_W-1:0] oval_r,     oval_nxt;
  logic             olast_r,    olast_nxt;

  plc_ctl_t         ctl;
  logic [VAL_W-1:0] cells [DEPTH];
  logic             slot_free;
  logic             acc;
  logic             pos_ge;
  logic [CNT_W-1:0] rem_at;
  logic [VAL_W-1:0] rem_val;

  assign slot_free = !ovalid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign pos_ge    = (POS_W'(occ_r) <= in_position);

  // Chain of cells; each hands its entry to its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cells[i+1];
    end
    plc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .data_o    (cells[i])
    );
  end

  // Entry leaving the list on a removal.
  assign rem_val = cells[rem_at[IDX_W-1:0]];

  // Sequencer: decodes actions, drives the chain and fills the result register.
  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    dcnt_nxt     = dcnt_r;
    ovalid_nxt   = ovalid_r && !out_ready;
    ostat_nxt    = ostat_r;
    oval_nxt     = oval_r;
    olast_nxt    = olast_r;
    ctl.op       = OP_HOLD;
    ctl.at       = '0;
    ctl.last_idx = occ_r - CNT_W'(1);
    ctl.din      = in_entry_value;
    ctl.head     = cells[0];
    rem_at       = '0;

    case (in_action)
      ACT_REM_TAIL: rem_at = occ_r - CNT_W'(1);
      ACT_REM_POS:  rem_at = CNT_W'(in_position);
      default:      rem_at = '0;
    endcase

    if (state_r == S_IDLE) begin
      if (acc) begin
        case (in_action)
          ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
            ovalid_nxt = 1'b1;
            oval_nxt   = '0;
            olast_nxt  = 1'b1;
            if (occ_r == CNT_W'(DEPTH)) begin
              ostat_nxt = STAT_FULL;
            end else begin
              ostat_nxt = STAT_DONE;
              ctl.op    = OP_INS;
              occ_nxt   = occ_r + CNT_W'(1);
              if (in_action == ACT_INS_HEAD) begin
                ctl.at = '0;
              end else if (in_action == ACT_INS_TAIL || pos_ge) begin
                ctl.at = occ_r;
              end else begin
                ctl.at = CNT_W'(in_position);
              end
            end
          end
          ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_POS: begin
            ovalid_nxt = 1'b1;
            olast_nxt  = 1'b1;
            if (occ_r == '0 || (in_action == ACT_REM_POS && pos_ge)) begin
              ostat_nxt = STAT_EMPTY;
              oval_nxt  = '0;
            end else begin
              ostat_nxt = STAT_DONE;
              oval_nxt  = rem_val;
              ctl.op    = OP_REM;
              ctl.at    = rem_at;
              occ_nxt   = occ_r - CNT_W'(1);
            end
          end
          ACT_DUMP: begin
            if (occ_r == '0) begin
              ovalid_nxt = 1'b1;
              ostat_nxt  = STAT_EMPTY;
              oval_nxt   = '0;
              olast_nxt  = 1'b1;
            end else begin
              state_nxt = S_DUMP;
              dcnt_nxt  = '0;
            end
          end
          default: begin
            ovalid_nxt = ovalid_r && !out_ready;
          end
        endcase
      end
    end else begin
      // Dump: emit the head and rotate the occupied part of the chain by one.
      if (slot_free) begin
        ovalid_nxt = 1'b1;
        ostat_nxt  = STAT_DUMP;
        oval_nxt   = cells[0];
        ctl.op     = OP_ROT;
        dcnt_nxt   = dcnt_r + IDX_W'(1);
        if (CNT_W'(dcnt_r) == occ_r - CNT_W'(1)) begin
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          olast_nxt = 1'b0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      dcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      dcnt_r   <= dcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_status       = ostat_r;
  assign out_result_value = oval_r;
  assign out_last_of_run  = olast_r;

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the positional list engine: random and directed actions.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import plc_pkg::*;

  // Action code that the engine takes and ignores.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 310;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLDOFF_AT   = 120;
  localparam int HOLDOFF_LEN  = 300;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIX} gen_mode_t;
  typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED, RX_TOGGLE} rx_mode_t;

  typedef struct {
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] entry_value;
  } list_cmd_t;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
    logic             last;
  } list_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ACT_W-1:0] in_action = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_entry_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic [VAL_W-1:0] out_result_value;
  logic             out_last_of_run;

  positional_list_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_last_of_run  (out_last_of_run)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  list_cmd_t        pending_cmds[$];
  list_result_t     expected_results[$];
  logic [VAL_W-1:0] stored_handles[$];
  list_result_t     got_result;
  list_result_t     want_result;

  int  n_errors = 0;
  int  cycle_cnt = 0;
  int  n_sent = 0;
  int  n_real = 0;
  int  gen_count = 0;
  bit  in_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  rx_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  bit  holdoff = 1'b0;

  // One line per mismatch; only the first few are printed, all are counted.
  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic push_result(input logic [ST_W-1:0] st, input logic [VAL_W-1:0] v,
                             input logic lst);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.last   = lst;
    expected_results.push_back(r);
  endtask

  // Applies one accepted action to the shadow list and queues its results.
  task automatic predict_action(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] v);
    int cnt;
    int at;
    logic [VAL_W-1:0] removed;
    cnt = stored_handles.size();
    case (act)
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
        if (cnt >= DEPTH) begin
          push_result(STAT_FULL, '0, 1'b1);
        end else begin
          if (act == ACT_INS_HEAD) stored_handles.push_front(v);
          else if (act == ACT_INS_TAIL || int'(pos) >= cnt) stored_handles.push_back(v);
          else stored_handles.insert(int'(pos), v);
          push_result(STAT_DONE, '0, 1'b1);
        end
      end
      ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_POS: begin
        if (act == ACT_REM_HEAD) at = 0;
        else if (act == ACT_REM_TAIL) at = cnt - 1;
        else at = int'(pos);
        if (cnt == 0 || at >= cnt) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          removed = stored_handles[at];
          stored_handles.delete(at);
          push_result(STAT_DONE, removed, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (cnt == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < cnt; i++)
            push_result(STAT_DUMP, stored_handles[i], (i == cnt - 1));
        end
      end
      default: ;
    endcase
  endtask

  // Queues one command and tracks the count the list will have after it.
  task automatic add_cmd(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] v);
    list_cmd_t c;
    c.action      = act;
    c.position    = pos;
    c.entry_value = v;
    pending_cmds.push_back(c);
    case (act)
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: if (gen_count < DEPTH) gen_count++;
      ACT_REM_HEAD, ACT_REM_TAIL: if (gen_count > 0) gen_count--;
      ACT_REM_POS: if (int'(pos) < gen_count) gen_count--;
      default: ;
    endcase
    if (act != ACT_UNUSED) n_real++;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return POS_W'($urandom_range(0, gen_count));
    if (roll < 85) return POS_W'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return POS_W'(gen_count);
      default: return POS_W'((gen_count > 0) ? gen_count - 1 : 0);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  // Driver: offers commands in bursts with random gaps, changes inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Hold the offered command until its transfer.
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        n_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        list_cmd_t c;
        c = pending_cmds.pop_front();
        in_valid       <= 1'b1;
        in_action      <= c.action;
        in_position    <= c.position;
        in_entry_value <= c.entry_value;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // One long hold-off of the receiver once enough commands are in.
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
    end else if (!holdoff_done && n_sent >= HOLDOFF_AT) begin
      holdoff_left = HOLDOFF_LEN;
      holdoff_done = 1'b1;
    end
    holdoff = (holdoff_left > 0);
  end

  // Receiver: stalls on a pattern that switches mode at random times.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 64);
    end else begin
      rx_left--;
    end
    if (holdoff) out_ready <= 1'b0;
    else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_BUSY:   out_ready <= ($urandom_range(0, 9) < 7);
        RX_CHOKED: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  // Monitor: checks each result transfer, then predicts from each input transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_result.status = out_status;
        got_result.value  = out_result_value;
        got_result.last   = out_last_of_run;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d value=%h last=%b",
                                    got_result.status, got_result.value, got_result.last));
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.status !== want_result.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got_result.status, want_result.status));
          if (got_result.value !== want_result.value)
            report_mismatch($sformatf("result_value %h, expected %h",
                                      got_result.value, want_result.value));
          if (got_result.last !== want_result.last)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      got_result.last, want_result.last));
        end
      end
      if (in_valid && in_ready) begin
        predict_action(in_action, in_position, in_entry_value);
        in_taken = 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    gen_mode_t mode;
    int seg_left;
    int roll;
    int ins_share;
    logic [ACT_W-1:0] act;

    // Directed part: empty-list cases, inserts at head, tail, inside and past the end, out-of-range removes.
    add_cmd(ACT_DUMP, '0, '0);
    add_cmd(ACT_REM_HEAD, '0, '0);
    add_cmd(ACT_REM_TAIL, '1, '1);
    add_cmd(ACT_REM_POS, '0, '0);
    add_cmd(ACT_INS_POS, '1, 16'h0000);
    add_cmd(ACT_INS_HEAD, '0, 16'hFFFF);
    add_cmd(ACT_INS_TAIL, '0, 16'hA5A5);
    add_cmd(ACT_INS_POS, 7'd1, 16'h5A5A);
    add_cmd(ACT_INS_POS, 7'd4, 16'h1234);
    add_cmd(ACT_INS_POS, 7'd64, 16'h8001);
    add_cmd(ACT_DUMP, '1, '1);
    add_cmd(ACT_REM_POS, '1, '0);
    add_cmd(ACT_REM_POS, 7'd6, '0);
    add_cmd(ACT_REM_POS, 7'd2, '0);
    add_cmd(ACT_REM_POS, 7'd0, '0);
    add_cmd(ACT_UNUSED, '1, '1);
    add_cmd(ACT_REM_HEAD, '0, '0);
    add_cmd(ACT_REM_TAIL, '0, '0);
    add_cmd(ACT_DUMP, '0, '0);
    add_cmd(ACT_REM_TAIL, '0, '0);
    add_cmd(ACT_DUMP, '0, '0);
    add_cmd(ACT_INS_HEAD, '0, 16'h0001);

    // Random part in segments that fill, drain or churn the list.
    n_real = 0;
    mode = GEN_FILL;
    seg_left = 70;
    while (n_real < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        mode = gen_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(30, 60);
      end
      seg_left--;
      case (mode)
        GEN_FILL:  ins_share = 75;
        GEN_DRAIN: ins_share = 15;
        default:   ins_share = 45;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 8) act = ACT_DUMP;
      else if (roll < 11) act = ACT_UNUSED;
      else if (roll < 11 + ins_share) act = ACT_INS_HEAD + ACT_W'($urandom_range(0, 2));
      else act = ACT_REM_HEAD + ACT_W'($urandom_range(0, 2));
      add_cmd(act, pick_position(), pick_value());
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hdl/plc_pkg.sv
hdl/plc_cell.sv
hdl/positional_list_engine.sv
verif/tb.sv
